// ===== rtl/core/m3i_pkg.sv =====
// package for the 3x3 matrix inverse core: widths, item types and queue entry type
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package m3i_pkg;

   localparam int ELEM_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
   localparam int COF_WIDTH   = PROD_WIDTH + 1;
   localparam int DET_WIDTH   = 3 * ELEM_WIDTH + 2;
   localparam int NUM_WIDTH   = COF_WIDTH + 2 * FRAC_BITS;
   localparam int QUO_WIDTH   = ELEM_WIDTH;
   localparam int REM_WIDTH   = DET_WIDTH + QUO_WIDTH + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   typedef struct packed {
      elem_type inv00;
      elem_type inv01;
      elem_type inv02;
      elem_type inv10;
      elem_type inv11;
      elem_type inv12;
      elem_type inv20;
      elem_type inv21;
      elem_type inv22;
      logic     singular;
      logic     saturated;
   } rsp_type;

   // one classified item: cofactor magnitudes in output order, result signs, |det|
   typedef struct packed {
      logic [8:0][COF_WIDTH-1:0] mag;
      logic [8:0]                neg;
      logic [DET_WIDTH-1:0]      det;
      logic                      singular;
   } job_type;

endpackage

// ===== rtl/core/mat3_inverse_core.sv =====
// top level of the 3x3 matrix inverse core: front pipeline, queue, back pipeline
// depends on m3i_pkg, m3i_front, m3i_queue, m3i_back
//
//   channel   ports                        transfer
//   request   start, busy, req_data        start high and busy low at the clock edge
//   response  rsp_valid, rsp_data          one cycle strobe, no back pressure
//
// one item per cycle while busy is low; items pass the front pipeline, queue and back pipeline
// the back pipeline holds nine 32-stage dividers, one quotient bit per stage
// busy rises only when the queue between front and back is full
// synchronous active-high reset clears the valid bits and the queue pointers
`timescale 1ns / 1ps

module mat3_inverse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  m3i_pkg::req_type  req_data,
   output logic              rsp_valid,
   output m3i_pkg::rsp_type  rsp_data
);

   logic             accept;
   logic             job_valid;
   m3i_pkg::job_type job;
   logic             head_valid;
   m3i_pkg::job_type head;
   logic             full;

   assign accept = start && !busy;
   assign busy   = full;

   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (accept),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job)
   );

   m3i_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job),
      .pop       (1'b1),
      .pop_valid (head_valid),
      .pop_data  (head),
      .full      (full)
   );

   m3i_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .job       (head),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/m3i_front.sv =====
// front pipeline: cofactors, determinant and sign classification of one item per cycle
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  m3i_pkg::req_type  req_data,
   output logic              job_valid,
   output m3i_pkg::job_type  job
);

   localparam int W  = m3i_pkg::ELEM_WIDTH;
   localparam int PW = m3i_pkg::PROD_WIDTH;
   localparam int CW = m3i_pkg::COF_WIDTH;
   localparam int DW = m3i_pkg::DET_WIDTH;

   logic [6:1] vld_ff;
   logic [6:1] vld_in;

   logic signed [W-1:0]  a_in [3][3];
   logic signed [W-1:0]  a_ff [3][3];
   logic signed [PW-1:0] pa_in [3][3];
   logic signed [PW-1:0] pb_in [3][3];
   logic signed [PW-1:0] pa_ff [3][3];
   logic signed [PW-1:0] pb_ff [3][3];
   logic signed [W-1:0]  r0s2_ff [3];
   logic signed [W-1:0]  r0s3_ff [3];
   logic signed [CW-1:0] cof_in [3][3];
   logic signed [CW-1:0] cof3_ff [3][3];
   logic signed [CW-1:0] cof4_ff [3][3];
   logic signed [CW-1:0] cof5_ff [3][3];
   logic signed [CW-1:0] cof6_ff [3][3];
   logic signed [CW-1:0] pl_in [3];
   logic signed [CW-1:0] ph_in [3];
   logic signed [CW-1:0] pl_ff [3];
   logic signed [CW-1:0] ph_ff [3];
   logic signed [DW-1:0] term_in [3];
   logic signed [DW-1:0] term_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;

   assign vld_in = {vld_ff[5:1], req_valid};

   always_comb begin
      a_in[0][0] = req_data.a00;
      a_in[0][1] = req_data.a01;
      a_in[0][2] = req_data.a02;
      a_in[1][0] = req_data.a10;
      a_in[1][1] = req_data.a11;
      a_in[1][2] = req_data.a12;
      a_in[2][0] = req_data.a20;
      a_in[2][1] = req_data.a21;
      a_in[2][2] = req_data.a22;
   end

   for (genvar gr = 0; gr < 3; gr++) begin : g_row
      localparam int R1 = (gr + 1) % 3;
      localparam int R2 = (gr + 2) % 3;
      for (genvar gc = 0; gc < 3; gc++) begin : g_col
         localparam int C1 = (gc + 1) % 3;
         localparam int C2 = (gc + 2) % 3;
         assign pa_in[gr][gc]  = a_ff[R1][C1] * a_ff[R2][C2];
         assign pb_in[gr][gc]  = a_ff[R1][C2] * a_ff[R2][C1];
         assign cof_in[gr][gc] = CW'(pa_ff[gr][gc]) - CW'(pb_ff[gr][gc]);
      end
   end

   // row 0 expansion, cofactor split into an unsigned low and a signed high half
   for (genvar gc = 0; gc < 3; gc++) begin : g_det
      assign pl_in[gc] = r0s3_ff[gc] * $signed({1'b0, cof3_ff[0][gc][W-1:0]});
      assign ph_in[gc] = r0s3_ff[gc] * $signed(cof3_ff[0][gc][CW-1:W]);
      assign term_in[gc] = (DW'(ph_ff[gc]) <<< W) + DW'(pl_ff[gc]);
   end

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      a_ff    <= a_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      r0s2_ff <= a_ff[0];
      r0s3_ff <= r0s2_ff;
      cof3_ff <= cof_in;
      cof4_ff <= cof3_ff;
      cof5_ff <= cof4_ff;
      cof6_ff <= cof5_ff;
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      term_ff <= term_in;
      det_ff  <= det_in;
   end

   // output element (r, c) takes cofactor (c, r)
   always_comb begin
      job.det      = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      job.singular = (det_ff == '0);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            job.mag[r*3+c] = cof6_ff[c][r][CW-1] ? CW'(-cof6_ff[c][r]) : CW'(cof6_ff[c][r]);
            job.neg[r*3+c] = cof6_ff[c][r][CW-1] ^ det_ff[DW-1];
         end
      end
   end

   assign job_valid = vld_ff[6];

endmodule

// ===== rtl/core/m3i_queue.sv =====
// short queue between the front and back pipelines
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  m3i_pkg::job_type  push_data,
   input  logic              pop,
   output logic              pop_valid,
   output m3i_pkg::job_type  pop_data,
   output logic              full
);

   localparam int D  = m3i_pkg::QUEUE_DEPTH;
   localparam int PB = m3i_pkg::QPTR_WIDTH;
   localparam int CB = m3i_pkg::QCNT_WIDTH;

   m3i_pkg::job_type entry_ff [D];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == CB'(D));
   assign do_pop    = pop && pop_valid;
   assign do_push   = push && !full;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(D - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(D - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CB'(do_push) - CB'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/m3i_back.sv =====
// back pipeline: nine restoring dividers, one quotient bit per stage, then saturation and zeroing of singular items
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  m3i_pkg::job_type  job,
   output logic              rsp_valid,
   output m3i_pkg::rsp_type  rsp_data
);

   localparam int W  = m3i_pkg::ELEM_WIDTH;
   localparam int F  = m3i_pkg::FRAC_BITS;
   localparam int DW = m3i_pkg::DET_WIDTH;
   localparam int Q  = m3i_pkg::QUO_WIDTH;
   localparam int RW = m3i_pkg::REM_WIDTH;

   typedef struct packed {
      logic [DW-1:0] det;
      logic [8:0]    neg;
      logic [8:0]    ovf;
      logic          singular;
   } ctl_type;

   logic [Q:0]    vld_ff;
   logic [RW-1:0] rem_ff [Q+1][9];
   logic [RW-1:0] rem_in [Q+1][9];
   logic [Q-1:0]  quo_ff [Q+1][9];
   logic [Q-1:0]  quo_in [Q+1][9];
   ctl_type       ctl_ff [Q+1];
   ctl_type       ctl_in;
   logic [RW-1:0] num0 [9];
   logic [RW-1:0] dsh0;
   logic [W-1:0]  val [9];
   logic [Q-1:0]  lim;
   logic          rsp_valid_ff;
   m3i_pkg::rsp_type rsp_ff, rsp_in;

   assign dsh0 = RW'(job.det) << Q;

   always_comb begin
      ctl_in.det      = job.det;
      ctl_in.neg      = job.neg;
      ctl_in.singular = job.singular;
      for (int k = 0; k < 9; k++) begin
         num0[k]      = RW'({job.mag[k], {(2*F){1'b0}}});
         ctl_in.ovf[k] = (num0[k] >= dsh0);
         rem_in[0][k] = num0[k];
         quo_in[0][k] = '0;
      end
   end

   for (genvar gs = 1; gs <= Q; gs++) begin : g_stage
      localparam int B = Q - gs;
      logic [RW-1:0] dd;
      assign dd = RW'(ctl_ff[gs-1].det) << B;
      for (genvar gk = 0; gk < 9; gk++) begin : g_lane
         always_comb begin
            rem_in[gs][gk] = rem_ff[gs-1][gk];
            quo_in[gs][gk] = quo_ff[gs-1][gk];
            if (rem_ff[gs-1][gk] >= dd) begin
               rem_in[gs][gk]    = rem_ff[gs-1][gk] - dd;
               quo_in[gs][gk][B] = 1'b1;
            end
         end
      end
   end

   assign lim = Q'(1) << (W - 1);

   always_comb begin
      logic [Q-1:0] q;
      logic         clip;
      rsp_in.saturated = 1'b0;
      for (int k = 0; k < 9; k++) begin
         q    = quo_ff[Q][k];
         clip = 1'b0;
         if (ctl_ff[Q].neg[k]) begin
            if (ctl_ff[Q].ovf[k] || q > lim) begin
               q    = lim;
               clip = 1'b1;
            end
            val[k] = W'('0 - q);
         end else begin
            if (ctl_ff[Q].ovf[k] || q > lim - 1'b1) begin
               q    = lim - 1'b1;
               clip = 1'b1;
            end
            val[k] = W'(q);
         end
         if (ctl_ff[Q].singular) begin
            val[k] = '0;
         end else begin
            rsp_in.saturated = rsp_in.saturated | clip;
         end
      end
      rsp_in.inv00    = val[0];
      rsp_in.inv01    = val[1];
      rsp_in.inv02    = val[2];
      rsp_in.inv10    = val[3];
      rsp_in.inv11    = val[4];
      rsp_in.inv12    = val[5];
      rsp_in.inv20    = val[6];
      rsp_in.inv21    = val[7];
      rsp_in.inv22    = val[8];
      rsp_in.singular = ctl_ff[Q].singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[Q-1:0], in_valid};
         rsp_valid_ff <= vld_ff[Q];
      end
      rem_ff[0] <= rem_in[0];
      quo_ff[0] <= quo_in[0];
      ctl_ff[0] <= ctl_in;
      for (int s = 1; s <= Q; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         ctl_ff[s] <= ctl_ff[s-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/tb_mat3_inverse_core.sv =====
// testbench for mat3_inverse_core: drives 3x3 matrices and checks each inverse
// against a fixed-point adjugate predictor; depends on m3i_pkg and the core rtl
`timescale 1ns / 1ps

module tb_mat3_inverse_core;

   localparam int LATENCY = 41;

   typedef logic signed [191:0] wide_t;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   m3i_pkg::req_type req_data;
   logic             rsp_valid;
   m3i_pkg::rsp_type rsp_data;

   m3i_pkg::rsp_type inverse_queue[$];
   int      error_count;
   int      sent_count;

   mat3_inverse_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   // truncated quotient, clipped to the element range
   function automatic m3i_pkg::elem_type clip_quotient(wide_t num, wide_t den,
                                                       ref logic sat);
      wide_t q;
      wide_t hi;
      wide_t lo;
      q  = num / den;
      hi = (wide_t'(1) <<< (m3i_pkg::ELEM_WIDTH - 1)) - 1;
      lo = -(wide_t'(1) <<< (m3i_pkg::ELEM_WIDTH - 1));
      if (q > hi) begin
         sat = 1'b1;
         return m3i_pkg::elem_type'(hi);
      end
      if (q < lo) begin
         sat = 1'b1;
         return m3i_pkg::elem_type'(lo);
      end
      return m3i_pkg::elem_type'(q);
   endfunction

   function automatic m3i_pkg::rsp_type invert_matrix(m3i_pkg::req_type m);
      wide_t   a[3][3];
      wide_t   cof[3][3];
      wide_t   det;
      m3i_pkg::rsp_type res;
      logic    sat;
      m3i_pkg::elem_type v[9];
      int r1, r2, c1, c2;
      a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
      a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
      a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
      for (int r = 0; r < 3; r++) begin
         r1 = (r + 1) % 3;
         r2 = (r + 2) % 3;
         for (int c = 0; c < 3; c++) begin
            c1 = (c + 1) % 3;
            c2 = (c + 2) % 3;
            cof[r][c] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
         end
      end
      det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      res = '0;
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      sat = 1'b0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            v[r * 3 + c] = clip_quotient(cof[c][r] <<< (2 * m3i_pkg::FRAC_BITS), det, sat);
      res.inv00 = v[0]; res.inv01 = v[1]; res.inv02 = v[2];
      res.inv10 = v[3]; res.inv11 = v[4]; res.inv12 = v[5];
      res.inv20 = v[6]; res.inv21 = v[7]; res.inv22 = v[8];
      res.saturated = sat;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // checks each response strobe against the oldest prediction
   always @(posedge clock) begin
      m3i_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (inverse_queue.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.inv00, 0);
         end else begin
            want = inverse_queue.pop_front();
            if (rsp_data.inv00 !== want.inv00) report_mismatch("inv00", rsp_data.inv00, want.inv00);
            if (rsp_data.inv01 !== want.inv01) report_mismatch("inv01", rsp_data.inv01, want.inv01);
            if (rsp_data.inv02 !== want.inv02) report_mismatch("inv02", rsp_data.inv02, want.inv02);
            if (rsp_data.inv10 !== want.inv10) report_mismatch("inv10", rsp_data.inv10, want.inv10);
            if (rsp_data.inv11 !== want.inv11) report_mismatch("inv11", rsp_data.inv11, want.inv11);
            if (rsp_data.inv12 !== want.inv12) report_mismatch("inv12", rsp_data.inv12, want.inv12);
            if (rsp_data.inv20 !== want.inv20) report_mismatch("inv20", rsp_data.inv20, want.inv20);
            if (rsp_data.inv21 !== want.inv21) report_mismatch("inv21", rsp_data.inv21, want.inv21);
            if (rsp_data.inv22 !== want.inv22) report_mismatch("inv22", rsp_data.inv22, want.inv22);
            if (rsp_data.singular !== want.singular)
               report_mismatch("singular", rsp_data.singular, want.singular);
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", rsp_data.saturated, want.saturated);
         end
      end
   end

   // drives one item and holds it until accepted; gap drawn per item
   task automatic send_matrix(m3i_pkg::req_type m, bit allow_gap);
      int gap;
      gap = allow_gap ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
      inverse_queue.push_back(invert_matrix(m));
      sent_count++;
   endtask

   function automatic m3i_pkg::elem_type rand_elem(int kind);
      case (kind)
         0: return m3i_pkg::elem_type'($urandom);
         1: return m3i_pkg::elem_type'($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
         2: return m3i_pkg::elem_type'($urandom_range(0, 255)) - 32'sd128;
         3: return m3i_pkg::elem_type'(int'($urandom_range(0, 8)) - 4) <<< m3i_pkg::FRAC_BITS;
         default: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      endcase
   endfunction

   function automatic m3i_pkg::req_type rand_matrix();
      m3i_pkg::req_type m;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind > 4) kind = 1;
      m.a00 = rand_elem(kind); m.a01 = rand_elem(kind); m.a02 = rand_elem(kind);
      m.a10 = rand_elem(kind); m.a11 = rand_elem(kind); m.a12 = rand_elem(kind);
      m.a20 = rand_elem(kind); m.a21 = rand_elem(kind); m.a22 = rand_elem(kind);
      // occasionally force a repeated row so the determinant is zero
      if ($urandom_range(0, 15) == 0) begin
         m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end
      return m;
   endfunction

   function automatic m3i_pkg::req_type diag_matrix(m3i_pkg::elem_type d0,
                                                    m3i_pkg::elem_type d1,
                                                    m3i_pkg::elem_type d2);
      m3i_pkg::req_type m;
      m = '0;
      m.a00 = d0;
      m.a11 = d1;
      m.a22 = d2;
      return m;
   endfunction

   task automatic test_directed();
      m3i_pkg::req_type m;
      send_matrix(diag_matrix(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000), 0);
      send_matrix('0, 0);
      send_matrix(diag_matrix(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000), 0);
      // tiny diagonal overflows every nonzero entry
      send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1), 1);
      send_matrix(diag_matrix(-32'sd1, 32'sd1, 32'sd1), 1);
      send_matrix(diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff), 1);
      send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1);
      send_matrix(diag_matrix(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000), 1);
      send_matrix('1, 1);
      m = '1;
      m.a00 = 32'sh8000_0000;
      send_matrix(m, 1);
      // rank-deficient: equal rows
      m = '0;
      m.a00 = 32'sh0001_0000; m.a01 = 32'sh0002_0000; m.a02 = 32'sh0003_0000;
      m.a10 = m.a00; m.a11 = m.a01; m.a12 = m.a02;
      m.a22 = 32'sh0001_0000;
      send_matrix(m, 0);
      // permutation with a negative entry
      m = '0;
      m.a01 = 32'sh0001_0000; m.a12 = -32'sh0002_0000; m.a20 = 32'sh0000_4000;
      send_matrix(m, 0);
      // negative half on the diagonal
      send_matrix(diag_matrix(-32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000), 1);
      // one past the positive limit, then exactly the negative limit
      send_matrix(diag_matrix(32'sd2, 32'sh0001_0000, 32'sh0001_0000), 1);
      send_matrix(diag_matrix(-32'sd2, 32'sh0001_0000, 32'sh0001_0000), 1);
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < 200; i++) send_matrix(rand_matrix(), 0);
   endtask

   task automatic test_random_gaps();
      for (int i = 0; i < 840; i++) send_matrix(rand_matrix(), ($urandom_range(0, 4) != 0));
   endtask

   initial begin
      int waited;
      error_count = 0;
      sent_count  = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_random_gaps();
      start <= 1'b0;
      waited = 0;
      while (inverse_queue.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (inverse_queue.size() != 0) begin
         $display("missing %0d responses", inverse_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
